@@ rtl/assert_macros.svh @@
// Assertion helpers for the hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, a, c)
`define CHK_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/sha224_pkg.sv @@
`default_nettype none
package sha224_pkg;
	localparam int QueueDepth = 4;
	localparam int DigestWords = 7;
	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos = 6'd56;

	// Front-to-back queue entry.
	typedef struct packed {
		logic [7:0] data;
		logic       bvalid;
		logic       last;
	} item_t;

	localparam logic [31:0] InitHash [8] = '{
		32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
		32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

@@ rtl/sha224_fifo.sv @@
`default_nettype none
// Small item queue between the input front and the hashing back end.
module sha224_fifo #(
	parameter int Depth = sha224_pkg::QueueDepth
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire sha224_pkg::item_t   wr_item,
	output logic                     full,
	input  wire logic                rd_en,
	output sha224_pkg::item_t        rd_item,
	output logic                     empty
);
	localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

	sha224_pkg::item_t mem_q [Depth];
	logic [Aw-1:0] wp_q, rp_q;
	logic [Aw:0]   cnt_q;

	assign full = (cnt_q == (Aw+1)'(Depth));
	assign empty = (cnt_q == '0);
	assign rd_item = mem_q[rp_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q] <= wr_item;
	end

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !full)
				wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en && !empty)
				rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(wr_en && !full) - (Aw+1)'(rd_en && !empty);
		end
	end
endmodule
`default_nettype wire

@@ rtl/sha224_core.sv @@
`default_nettype none
// Back end: packs bytes, pads, runs the rounds one per cycle, emits the digest.
module sha224_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha224_pkg::item_t item,
	input  wire logic              item_avail,
	output logic                   item_take,
	output logic [31:0]            digest_word,
	output logic [2:0]             word_index,
	output logic                   last_word,
	output logic                   out_valid,
	input  wire logic              out_take
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StPad  = 3'd1;
	localparam logic [2:0] StLoad = 3'd2;
	localparam logic [2:0] StRnd  = 3'd3;
	localparam logic [2:0] StAdd  = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [63:0] total_q;
	logic        fin_q;
	logic        final_blk_q;
	logic [5:0]  pidx_q;
	logic [5:0]  rnd_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [2:0]  oidx_q;

	logic [31:0] wnew, wcur, t1, t2;
	logic [31:0] w2, w15;
	logic [3:0]  r4;
	logic [7:0]  pad_b;

	assign r4 = rnd_q[3:0];
	assign w2 = w_q[4'(r4 - 4'd2)];
	assign w15 = w_q[4'(r4 - 4'd15)];

	// Message schedule and round function.
	always_comb begin
		wnew = (sha224_pkg::rotr(w2, 17) ^ sha224_pkg::rotr(w2, 19) ^ (w2 >> 10))
			+ w_q[4'(r4 - 4'd7)]
			+ (sha224_pkg::rotr(w15, 7) ^ sha224_pkg::rotr(w15, 18) ^ (w15 >> 3))
			+ w_q[r4];
		wcur = (rnd_q < 6'd16) ? w_q[r4] : wnew;
		t1 = v_q[7] + (sha224_pkg::rotr(v_q[4], 6) ^ sha224_pkg::rotr(v_q[4], 11)
			^ sha224_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha224_pkg::RoundK[rnd_q] + wcur;
		t2 = (sha224_pkg::rotr(v_q[0], 2) ^ sha224_pkg::rotr(v_q[0], 13)
			^ sha224_pkg::rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// Padding byte for the current sweep position.
	always_comb begin
		if (pidx_q >= sha224_pkg::LenPos && final_blk_q)
			pad_b = total_q[8*(7 - int'(pidx_q[2:0])) +: 8];
		else if (pidx_q == fill_q && !fin_q)
			pad_b = sha224_pkg::PadByte;
		else
			pad_b = 8'h00;
	end

	assign item_take = (state_q == StIdle) && item_avail;
	assign out_valid = (state_q == StOut);
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign last_word = (oidx_q == 3'(sha224_pkg::DigestWords - 1));

	// Bytes are packed big-endian straight into the schedule words, then the
	// rounds run on the same words.
	always_ff @(posedge clk) begin
		if (item_take && item.bvalid) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= item.data;
		end else if (state_q == StPad) begin
			w_q[pidx_q[5:2]][{~pidx_q[1:0], 3'b000} +: 8] <= pad_b;
		end else if (state_q == StLoad) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == StRnd) begin
			if (rnd_q >= 6'd16) w_q[r4] <= wnew;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			fill_q <= '0;
			len_q <= '0;
			total_q <= '0;
			fin_q <= 1'b0;
			final_blk_q <= 1'b0;
			pidx_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha224_pkg::InitHash[i];
		end else begin
			unique case (state_q)
				StIdle: if (item_take) begin
					if (item.bvalid && fill_q == 6'd63) begin
						fill_q <= '0;
						len_q <= len_q + 64'd512;
						final_blk_q <= 1'b0;
						fin_q <= item.last;
						state_q <= StLoad;
					end else begin
						fill_q <= fill_q + 6'(item.bvalid);
						if (item.last) begin
							total_q <= len_q + {55'd0, fill_q + 6'(item.bvalid), 3'd0};
							final_blk_q <= (fill_q + 6'(item.bvalid)) < sha224_pkg::LenPos;
							pidx_q <= fill_q + 6'(item.bvalid);
							fill_q <= fill_q + 6'(item.bvalid);
							fin_q <= 1'b0;
							state_q <= StPad;
						end
					end
				end
				StPad: begin
					pidx_q <= pidx_q + 1'b1;
					if (pidx_q == 6'd63) state_q <= StLoad;
				end
				StLoad: begin
					rnd_q <= '0;
					state_q <= StRnd;
				end
				StRnd: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) state_q <= StAdd;
				end
				StAdd: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (final_blk_q) begin
						oidx_q <= '0;
						state_q <= StOut;
					end else if (fin_q) begin
						// Full block ended the message: padding goes in a new block.
						total_q <= len_q;
						final_blk_q <= 1'b1;
						pidx_q <= '0;
						fill_q <= '0;
						fin_q <= 1'b0;
						state_q <= StPad;
					end else if (pidx_q != '0 || fill_q != '0) begin
						// Overflow pad block done: length block follows.
						final_blk_q <= 1'b1;
						pidx_q <= '0;
						fill_q <= '0;
						fin_q <= 1'b1;
						state_q <= StPad;
					end else begin
						state_q <= StIdle;
					end
				end
				StOut: if (out_take) begin
					oidx_q <= oidx_q + 1'b1;
					if (oidx_q == 3'(sha224_pkg::DigestWords - 1)) begin
						for (int i = 0; i < 8; i++) h_q[i] <= sha224_pkg::InitHash[i];
						fill_q <= '0;
						len_q <= '0;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/sha224_byte_stream_hasher.sv @@
`default_nettype none
// Bytes pass a four-entry queue into the back end, which takes one byte a cycle
// while idle. A full block runs load, 64 rounds and add; the final block adds a
// padding sweep to the block end, and a second block when 56 or more bytes remain.
// No byte is taken while a block hashes or a digest waits; words leave one per pop.
// arst_n clears the queue, counters and chaining value to the initial hash.
`include "assert_macros.svh"
module sha224_byte_stream_hasher #(
	parameter int QueueDepth = sha224_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        last,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	sha224_pkg::item_t in_item, q_item;
	logic q_empty, q_take, out_valid;

	assign in_item = '{data: data_byte, bvalid: byte_valid, last: last};
	assign empty = !out_valid;

	sha224_fifo #(.Depth(QueueDepth)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(push), .wr_item(in_item), .full(full),
		.rd_en(q_take), .rd_item(q_item), .empty(q_empty));

	sha224_core u_core (
		.clk(clk), .arst_n(arst_n), .item(q_item), .item_avail(!q_empty),
		.item_take(q_take), .digest_word(digest_word), .word_index(word_index),
		.last_word(last_word), .out_valid(out_valid), .out_take(pop));

	`CHK_IMPL(a_last_idx, clk, arst_n, !empty && last_word, word_index == 3'd6)
	`CHK_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(word_index))
	`CHK_IMPL(a_no_take_out, clk, arst_n, !empty, !q_take)
endmodule
`default_nettype wire

@@ verif/sha224_byte_stream_hasher_test.sv @@
`default_nettype none
module sha224_byte_stream_hasher_test;
	localparam int StallLimit = 20000;

	// Directed stimulus row: byte, byte flag, end-of-message flag.
	typedef struct {
		logic [7:0] data;
		logic       bvalid;
		logic       last;
	} stim_row_t;

	// One digest word as the block should return it.
	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        final_word;
	} digest_entry_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        last;
	logic        empty;
	logic        pop;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// Predictor state for the message in progress.
	logic [7:0]  msg_block [64];
	logic [31:0] chain_hash [8];
	int unsigned msg_fill;
	logic [63:0] done_bits;

	digest_entry_t digest_queue [$];
	stim_row_t     directed_rows [$];
	int            error_count;
	int            idle_cycles;
	bit            hold_pop;

	sha224_byte_stream_hasher DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_byte(data_byte), .byte_valid(byte_valid), .last(last),
		.empty(empty), .pop(pop), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Run one 64-round compression of the buffered block into the chain.
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++) begin
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		end
		for (int i = 16; i < 64; i++) begin
			w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		end
		for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha224_pkg::RoundK[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain_hash[i] += v[i];
	endtask

	task automatic restart_message();
		for (int i = 0; i < 8; i++) chain_hash[i] = sha224_pkg::InitHash[i];
		msg_fill = 0;
		done_bits = '0;
	endtask

	// Absorb one accepted transfer and queue any digest words it produces.
	task automatic absorb_item(input logic [7:0] d, input logic bv, input logic lst);
		logic [63:0] total;
		digest_entry_t e;
		if (bv) begin
			msg_block[msg_fill] = d;
			msg_fill++;
			if (msg_fill == 64) begin
				compress_block();
				done_bits += 64'd512;
				msg_fill = 0;
			end
		end
		if (lst) begin
			total = done_bits + 64'(msg_fill) * 8;
			msg_block[msg_fill] = sha224_pkg::PadByte;
			for (int i = msg_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
			if (msg_fill >= sha224_pkg::LenPos) begin
				compress_block();
				for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++) msg_block[56 + i] = total[63 - 8*i -: 8];
			compress_block();
			for (int i = 0; i < sha224_pkg::DigestWords; i++) begin
				e.word = chain_hash[i];
				e.index = 3'(i);
				e.final_word = (i == sha224_pkg::DigestWords - 1);
				digest_queue.push_back(e);
			end
			restart_message();
		end
	endtask

	// Offer one item and wait for its transfer.
	task automatic send_item(input logic [7:0] d, input logic bv, input logic lst);
		push <= 1'b1;
		data_byte <= d;
		byte_valid <= bv;
		last <= lst;
		do @(posedge clk); while (full);
		absorb_item(d, bv, lst);
		@(negedge clk);
	endtask

	task automatic idle_gap(input int n);
		push <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Send a message of n random bytes, with the end flag on a byte or alone.
	task automatic send_message(input int n);
		bit ended;
		ended = 1'b0;
		bool_gap: for (int i = 0; i < n; i++) begin
			ended = (i == n - 1) && ($urandom_range(0, 1) == 1);
			send_item(8'($urandom), 1'b1, ended);
			if (ended) break;
			if ($urandom_range(0, 15) == 0) idle_gap($urandom_range(1, 6));
		end
		if (!ended) send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Compare every digest word transfer with the oldest expectation.
	always @(posedge clk) begin
		digest_entry_t e;
		if (arst_n && pop && !empty) begin
			if (digest_queue.size() == 0) begin
				$display("%0t: unexpected digest word %h index %0d", $time,
					digest_word, word_index);
				error_count++;
			end else begin
				e = digest_queue.pop_front();
				if (digest_word !== e.word || word_index !== e.index
						|| last_word !== e.final_word) begin
					$display("%0t: digest mismatch expected %h/%0d/%b actual %h/%0d/%b",
						$time, e.word, e.index, e.final_word,
						digest_word, word_index, last_word);
					error_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: stall pattern with quiet stretches and one long hold-off,
	// which it times on its own once requested.
	initial begin
		int phase;
		int hold_cnt;
		bit hold_seen;
		pop = 1'b0;
		phase = 0;
		hold_cnt = 0;
		hold_seen = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			phase++;
			if (hold_pop && !hold_seen) begin
				hold_cnt = 300;
				hold_seen = 1'b1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else if ((phase / 64) % 3 == 0) pop <= 1'b1;
			else pop <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		stim_row_t r;
		int burst;
		error_count = 0;
		idle_cycles = 0;
		hold_pop = 0;
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = 8'h00;
		byte_valid = 1'b0;
		last = 1'b0;
		restart_message();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty message, idle item, extremes, byte with end flag, abc.
		directed_rows = '{
			'{8'h00, 1'b0, 1'b1},
			'{8'hFF, 1'b0, 1'b0},
			'{8'h00, 1'b1, 1'b0},
			'{8'hFF, 1'b1, 1'b1},
			'{8'h61, 1'b1, 1'b0},
			'{8'h62, 1'b1, 1'b0},
			'{8'h63, 1'b1, 1'b0},
			'{8'hAA, 1'b0, 1'b1}
		};
		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			send_item(r.data, r.bvalid, r.last);
		end
		// The empty message has a well-known first word.
		if (digest_queue.size() == 21 && digest_queue[0].word !== 32'hd14a028c) begin
			$display("%0t: empty digest expected d14a028c actual %h", $time,
				digest_queue[0].word);
			error_count++;
		end

		// Padding boundaries: overflow into a length block, and a full block.
		send_message(56);
		send_message(64);

		// Long hold-off on the receiver while messages keep coming.
		hold_pop = 1;
		send_message(3);
		send_message(6);
		send_message(4);

		// Random short messages, some with a noise item in front.
		for (int m = 0; m < 4; m++) begin
			burst = $urandom_range(0, 6);
			if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
			send_message(burst);
			idle_gap($urandom_range(1, 8));
		end
		push <= 1'b0;

		while (digest_queue.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/sha224_pkg.sv
rtl/sha224_fifo.sv
rtl/sha224_core.sv
rtl/sha224_byte_stream_hasher.sv
verif/sha224_byte_stream_hasher_test.sv
